>>> hdl/ezop_pkg.sv
// Package for the even/zero/odd partition block.
// Sizes, source codes and the controller/datapath command and status structs.
// No dependencies.
`default_nettype none

package ezop_pkg;

	// list storage
	localparam int DEPTH  = 64;
	localparam int DATA_W = 32;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int SUM_W  = CNT_W + 2;

	// where a drained word comes from
	typedef enum logic [1:0] {
		SRC_EVEN,
		SRC_ZERO,
		SRC_ODD
	} src_t;

	// controller -> datapath
	typedef struct packed {
		logic load;    // input word accepted this cycle
		logic issue;   // start one drain read
		src_t src;     // group of the word issued
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic even_nz;    // evens left to drain
		logic zero_nz;    // zeros left to drain
		logic rem_one;    // the next issued word is the final one
		logic can_issue;  // room downstream for one more word
	} sts_t;

	// one word of the output queue
	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic              last;
		logic              ovf;
	} out_word_t;

endpackage

`default_nettype wire

>>> hdl/ezop_ifs.sv
// Handshake interfaces for the input and output channels.
// Depends on ezop_pkg.
`default_nettype none

interface ezop_in_if
	import ezop_pkg::*;
;
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] value;
	logic                     last;

	modport source (output valid, output value, output last, input ready);
	modport sink   (input valid, input value, input last, output ready);
endinterface

interface ezop_out_if
	import ezop_pkg::*;
;
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] value_res;
	logic                     last_res;
	logic                     overflow;

	modport source (output valid, output value_res, output last_res, output overflow,
		input ready);
	modport sink   (input valid, input value_res, input last_res, input overflow,
		output ready);
endinterface

`default_nettype wire

>>> hdl/ezop_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module ezop_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> hdl/ezop_datapath.sv
// Datapath: group counters, even stack and odd queue RAMs, read stage and
// a two-word output queue. Depends on ezop_pkg and ezop_ram.
`default_nettype none

module ezop_datapath
	import ezop_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cmd_t              cmd,
	output sts_t                   sts,
	input  wire logic [DATA_W-1:0] in_value,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic      [DATA_W-1:0] out_value,
	output logic                   out_last,
	output logic                   out_ovf
);

	logic [CNT_W-1:0]  even_cnt_q, zero_cnt_q, odd_cnt_q, odd_idx_q;
	logic              ovf_q;
	logic [SUM_W-1:0]  total, rem;
	logic              full, in_zero, in_odd;
	logic              even_we, odd_we;
	logic [ADDR_W-1:0] even_raddr;
	logic [DATA_W-1:0] even_rdata, odd_rdata;
	logic              final_issue;

	logic              v_s1, last_s1, ovf_s1;
	src_t              src_s1;
	out_word_t         push_word;

	out_word_t         fifo_q [2];
	logic              wr_ptr_q, rd_ptr_q;
	logic [1:0]        fifo_cnt_q;
	logic              push, pop;
	logic [2:0]        fill;

	// classify the incoming word
	assign total   = SUM_W'(even_cnt_q) + SUM_W'(zero_cnt_q) + SUM_W'(odd_cnt_q);
	assign full    = (total >= SUM_W'(DEPTH));
	assign in_zero = (in_value == '0);
	assign in_odd  = in_value[0];
	assign even_we = cmd.load && !full && !in_zero && !in_odd;
	assign odd_we  = cmd.load && !full && in_odd;

	// words still to drain
	assign rem         = total - SUM_W'(odd_idx_q);
	assign final_issue = cmd.issue && (rem == SUM_W'(1));
	assign even_raddr  = ADDR_W'(even_cnt_q - CNT_W'(1));

	// stores
	ezop_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_even_stack (
		.clk   (clk),
		.we    (even_we),
		.waddr (even_cnt_q[ADDR_W-1:0]),
		.wdata (in_value),
		.re    (cmd.issue && cmd.src == SRC_EVEN),
		.raddr (even_raddr),
		.rdata (even_rdata)
	);

	ezop_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_odd_queue (
		.clk   (clk),
		.we    (odd_we),
		.waddr (odd_cnt_q[ADDR_W-1:0]),
		.wdata (in_value),
		.re    (cmd.issue && cmd.src == SRC_ODD),
		.raddr (odd_idx_q[ADDR_W-1:0]),
		.rdata (odd_rdata)
	);

	// counters and overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			even_cnt_q <= '0;
			zero_cnt_q <= '0;
			odd_cnt_q  <= '0;
			odd_idx_q  <= '0;
			ovf_q      <= 1'b0;
		end else if (final_issue) begin
			even_cnt_q <= '0;
			zero_cnt_q <= '0;
			odd_cnt_q  <= '0;
			odd_idx_q  <= '0;
			ovf_q      <= 1'b0;
		end else if (cmd.load) begin
			if (full) begin
				ovf_q <= 1'b1;
			end else if (in_zero) begin
				zero_cnt_q <= zero_cnt_q + CNT_W'(1);
			end else if (in_odd) begin
				odd_cnt_q <= odd_cnt_q + CNT_W'(1);
			end else begin
				even_cnt_q <= even_cnt_q + CNT_W'(1);
			end
		end else if (cmd.issue) begin
			case (cmd.src)
				SRC_EVEN: even_cnt_q <= even_cnt_q - CNT_W'(1);
				SRC_ZERO: zero_cnt_q <= zero_cnt_q - CNT_W'(1);
				SRC_ODD:  odd_idx_q  <= odd_idx_q + CNT_W'(1);
				default:  odd_idx_q  <= odd_idx_q;
			endcase
		end
	end

	// read stage: tags travel alongside the RAM read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			src_s1  <= cmd.src;
			last_s1 <= final_issue;
			ovf_s1  <= ovf_q;
		end
	end

	always_comb begin
		case (src_s1)
			SRC_EVEN: push_word.value = even_rdata;
			SRC_ODD:  push_word.value = odd_rdata;
			default:  push_word.value = '0;
		endcase
		push_word.last = last_s1;
		push_word.ovf  = ovf_s1;
	end

	// output queue, two words
	assign push = v_s1;
	assign pop  = out_valid && out_ready;
	assign fill = 3'(fifo_cnt_q) + 3'(v_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= 1'b0;
			rd_ptr_q   <= 1'b0;
			fifo_cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			fifo_cnt_q <= fifo_cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= push_word;
		end
	end

	assign out_valid = (fifo_cnt_q != '0);
	assign out_value = fifo_q[rd_ptr_q].value;
	assign out_last  = fifo_q[rd_ptr_q].last;
	assign out_ovf   = fifo_q[rd_ptr_q].ovf;

	// status to the controller
	assign sts.even_nz   = (even_cnt_q != '0);
	assign sts.zero_nz   = (zero_cnt_q != '0);
	assign sts.rem_one   = (rem == SUM_W'(1));
	assign sts.can_issue = (fill <= 3'(1) + 3'(pop));

`ifndef SYNTHESIS
	// queue never takes a word it has no room for
	a_no_fifo_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> fifo_cnt_q < 2'd2)
		else $error("output queue overrun");

	// stored words never exceed the store depth
	a_total_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		total <= SUM_W'(DEPTH))
		else $error("stored word count above depth");

	// an even read always targets a written entry
	a_even_read_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue && cmd.src == SRC_EVEN |-> even_cnt_q != '0)
		else $error("even read with empty stack");

	// the final word of a list leaves all counters cleared
	a_clear_after_final: assert property (@(posedge clk) disable iff (!arst_n)
		final_issue |=> even_cnt_q == '0 && zero_cnt_q == '0 && odd_cnt_q == '0 && !ovf_q)
		else $error("counters not cleared after final word");
`endif

endmodule

`default_nettype wire

>>> hdl/ezop_ctrl.sv
// Controller: load/drain sequencing, input ready and drain read issue.
// Depends on ezop_pkg.
`default_nettype none

module ezop_ctrl
	import ezop_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire logic in_last,
	output logic      in_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	typedef enum logic {
		ST_LOAD,
		ST_DRAIN
	} state_t;

	state_t state_q;
	logic   ready_q;
	logic   accept;

	assign accept   = in_valid && ready_q;
	assign in_ready = ready_q;

	// commands: evens first, then zeros, then odds
	always_comb begin
		cmd.load  = accept;
		cmd.issue = (state_q == ST_DRAIN) && sts.can_issue;
		if (sts.even_nz) begin
			cmd.src = SRC_EVEN;
		end else if (sts.zero_nz) begin
			cmd.src = SRC_ZERO;
		end else begin
			cmd.src = SRC_ODD;
		end
	end

	// state and registered ready
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			ready_q <= 1'b1;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (accept && in_last) begin
						state_q <= ST_DRAIN;
						ready_q <= 1'b0;
					end
				end
				ST_DRAIN: begin
					if (cmd.issue && sts.rem_one) begin
						state_q <= ST_LOAD;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_LOAD;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> hdl/even_zero_odd_partition.sv
// Three-way partition of a list of signed 32-bit words. Words are taken one per
// cycle until the word marked last; the list is then sent back as the nonzero
// evens newest first, then the zeros, then the odds in arrival order, one word
// per cycle while the output is ready. Evens and odds are read through the
// single read port of their RAM. After the last word the controller enters its
// drain state, and each result passes the read stage and output queue before it
// is offered. Input is held off from the last word until the final result has
// been read from the stores. Words beyond 64 are dropped and every result of
// that list carries overflow. The RAMs need no clearing after reset.
// Depends on ezop_pkg, ezop_ifs, ezop_ctrl, ezop_datapath.
`default_nettype none

module even_zero_odd_partition
	import ezop_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	ezop_in_if.sink    ingress,
	ezop_out_if.source egress
);

	cmd_t              cmd;
	sts_t              sts;
	logic [DATA_W-1:0] out_value;

	ezop_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (ingress.valid),
		.in_last  (ingress.last),
		.in_ready (ingress.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ezop_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_value  (ingress.value),
		.out_valid (egress.valid),
		.out_ready (egress.ready),
		.out_value (out_value),
		.out_last  (egress.last_res),
		.out_ovf   (egress.overflow)
	);

	assign egress.value_res = signed'(out_value);

endmodule

`default_nettype wire
